[src/lfw_pkg.sv]
// Shared types and constants for the fully connected layer block.
`timescale 1ns / 1ps
`default_nettype none

package lfw_pkg;

  // Input transaction codes
  localparam logic [1:0] FUNC_WEIGHT = 2'd0;
  localparam logic [1:0] FUNC_BIAS   = 2'd1;
  localparam logic [1:0] FUNC_SAMPLE = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_SIZE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_ENABLE = 2'd2;

  localparam logic [6:0] INNER_SIZE_RST  = 7'd64;
  localparam logic [4:0] OUT_SIZE_RST    = 5'd16;
  localparam logic       BIAS_ENABLE_RST = 1'b1;

  localparam int ACC_W = 40;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]          func;
    logic [9:0]          index;
    logic signed [15:0]  value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0]  result;
    logic [3:0]          column;
    logic                row_last;
  } out_item_t;

  // Control into the shared multiply-accumulate unit
  typedef struct packed {
    logic vld;       // operands for one column present
    logic acc_keep;  // accumulator holds a value from this row
  } mac_ctl_t;

endpackage

`default_nettype wire

[src/lfw_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module lfw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[src/lfw_mac.sv]
// Shared multiply-accumulate unit: registered 16x16 product, then 40-bit add.
`timescale 1ns / 1ps
`default_nettype none

module lfw_mac #(
  parameter int COL_W = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire lfw_pkg::mac_ctl_t          ctl_i,
  input  wire logic [COL_W-1:0]           col_i,
  input  wire logic signed [15:0]         x_i,
  input  wire logic signed [15:0]         w_i,
  input  wire logic [lfw_pkg::ACC_W-1:0]  acc_i,
  output logic                            wr_en_o,
  output logic [COL_W-1:0]                wr_addr_o,
  output logic [lfw_pkg::ACC_W-1:0]       wr_data_o
);

  logic                      vld_r;
  logic [COL_W-1:0]          col_r;
  logic signed [31:0]        prod_r;
  logic [lfw_pkg::ACC_W-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= ctl_i.vld;
    end
    col_r  <= col_i;
    prod_r <= x_i * w_i;
    acc_r  <= ctl_i.acc_keep ? acc_i : '0;
  end

  // wraps modulo 2^40
  assign wr_en_o   = vld_r;
  assign wr_addr_o = col_r;
  assign wr_data_o = acc_r + {{(lfw_pkg::ACC_W-32){prod_r[31]}}, prod_r};

endmodule

`default_nettype wire

[src/linear_layer_forward_top.sv]
// Fully connected layer forward pass: sequencer, stores and output stage.
// Load transaction: written to its store in S_IDLE. Sample (ncol = effective out_size):
//   one shared MAC pass per column behind the registered weight/accumulator RAM reads.
// A row-ending sample then steps S_OUT_RD and S_OUT_SUM per result, held by out_stall.
// Reset: synchronous, active low; clears sequencer, sample count, accumulator valid
//   bits and output valid; config registers return to 64/16/1. RAMs keep contents.
`timescale 1ns / 1ps
`default_nettype none

module linear_layer_forward_top #(
  parameter int MAX_INNER = 64,
  parameter int MAX_OUT   = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire lfw_pkg::in_item_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output lfw_pkg::out_item_t                     out_data,
  input  wire logic                              cfg_we,
  input  wire logic [lfw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lfw_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int WDEPTH = MAX_OUT * MAX_INNER;
  localparam int WA_W   = WDEPTH > 1 ? $clog2(WDEPTH) : 1;
  localparam int COL_W  = MAX_OUT > 1 ? $clog2(MAX_OUT) : 1;
  localparam int NCNT_W = $clog2(MAX_OUT + 1);
  localparam int SC_W   = $clog2(MAX_INNER + 1);
  localparam int ACC_W  = lfw_pkg::ACC_W;

  typedef enum logic [1:0] {S_IDLE, S_MAC, S_OUT_RD, S_OUT_SUM} state_t;

  state_t                state_r, state_nxt;
  logic [6:0]            inner_size_r;
  logic [4:0]            out_size_r;
  logic                  bias_enable_r;
  logic [SC_W-1:0]       sc_r, sc_nxt;           // samples taken in this row
  logic                  row_end_r, row_end_nxt;
  logic signed [15:0]    x_r, x_nxt;
  logic [WA_W-1:0]       waddr_r, waddr_nxt;     // column*MAX_INNER + feature
  logic [NCNT_W-1:0]     iss_r, iss_nxt;         // next column to issue
  logic                  st1_vld_r, st1_vld_nxt;
  logic [COL_W-1:0]      st1_col_r, st1_col_nxt;
  logic [NCNT_W-1:0]     oc_r, oc_nxt;           // output column
  logic [MAX_OUT-1:0]    acc_vld_r, acc_vld_nxt; // accumulator written this row
  logic                  out_valid_r, out_valid_nxt;
  lfw_pkg::out_item_t    out_r, out_nxt;

  logic [NCNT_W-1:0]     ncol;
  logic [SC_W-1:0]       ninner;
  logic                  in_acc;
  logic                  out_free;
  logic                  mac_done;
  logic [SC_W-1:0]       feat;

  // RAM ports
  logic                  w_we, w_re;
  logic [15:0]           w_rdata;
  logic                  b_we, b_re;
  logic [15:0]           b_rdata;
  logic                  acc_re;
  logic [COL_W-1:0]      acc_raddr;
  logic [ACC_W-1:0]      acc_rdata;
  logic                  acc_we;
  logic [COL_W-1:0]      acc_waddr;
  logic [ACC_W-1:0]      acc_wdata;

  lfw_pkg::mac_ctl_t     mac_ctl;

  // Output sum path
  logic [ACC_W-1:0]      acc_sel;
  logic signed [ACC_W:0] sum;
  logic signed [31:0]    sat;

  // Effective sizes, clamped into their legal ranges
  always_comb begin
    if (out_size_r == 5'd0) begin
      ncol = NCNT_W'(1);
    end else if (32'(out_size_r) > MAX_OUT) begin
      ncol = NCNT_W'(MAX_OUT);
    end else begin
      ncol = NCNT_W'(out_size_r);
    end
    if (inner_size_r == 7'd0) begin
      ninner = SC_W'(1);
    end else if (32'(inner_size_r) > MAX_INNER) begin
      ninner = SC_W'(MAX_INNER);
    end else begin
      ninner = SC_W'(inner_size_r);
    end
  end

  assign feat     = (32'(sc_r) > MAX_INNER - 1) ? SC_W'(MAX_INNER - 1) : sc_r;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign mac_done = (iss_r == ncol) && !st1_vld_r && !acc_we;

  assign mac_ctl.vld      = st1_vld_r;
  assign mac_ctl.acc_keep = acc_vld_r[st1_col_r];

  assign acc_raddr = (state_r == S_MAC) ? iss_r[COL_W-1:0] : oc_r[COL_W-1:0];

  // Bias is Q8.8, moved to Q16.16 before the add; saturate to 32 bits
  always_comb begin
    acc_sel = acc_vld_r[oc_r[COL_W-1:0]] ? acc_rdata : '0;
    sum = $signed({acc_sel[ACC_W-1], acc_sel});
    if (bias_enable_r) begin
      sum = sum + $signed({{(ACC_W-23){b_rdata[15]}}, b_rdata, 8'd0});
    end
    if (sum[ACC_W:31] == '0 || sum[ACC_W:31] == '1) begin
      sat = sum[31:0];
    end else if (sum[ACC_W]) begin
      sat = lfw_pkg::SAT_MIN;
    end else begin
      sat = lfw_pkg::SAT_MAX;
    end
  end

  // Sequencer
  always_comb begin
    logic out_load;
    out_load      = 1'b0;
    state_nxt     = state_r;
    sc_nxt        = sc_r;
    row_end_nxt   = row_end_r;
    x_nxt         = x_r;
    waddr_nxt     = waddr_r;
    iss_nxt       = iss_r;
    st1_vld_nxt   = 1'b0;
    st1_col_nxt   = st1_col_r;
    oc_nxt        = oc_r;
    acc_vld_nxt   = acc_vld_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    w_we          = 1'b0;
    w_re          = 1'b0;
    b_we          = 1'b0;
    b_re          = 1'b0;
    acc_re        = 1'b0;

    if (acc_we) begin
      acc_vld_nxt[acc_waddr] = 1'b1;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data.func)
            lfw_pkg::FUNC_WEIGHT: w_we = (32'(in_data.index) < WDEPTH);
            lfw_pkg::FUNC_BIAS:   b_we = (32'(in_data.index) < MAX_OUT);
            lfw_pkg::FUNC_SAMPLE: begin
              x_nxt     = in_data.value;
              waddr_nxt = WA_W'(feat);
              iss_nxt   = '0;
              if ((SC_W+1)'(sc_r) + (SC_W+1)'(1) >= (SC_W+1)'(ninner)) begin
                row_end_nxt = 1'b1;
                sc_nxt      = '0;
              end else begin
                row_end_nxt = 1'b0;
                sc_nxt      = sc_r + SC_W'(1);
              end
              state_nxt = S_MAC;
            end
            default: ;
          endcase
        end
      end
      S_MAC: begin
        if (iss_r != ncol) begin
          w_re        = 1'b1;
          acc_re      = 1'b1;
          st1_vld_nxt = 1'b1;
          st1_col_nxt = iss_r[COL_W-1:0];
          iss_nxt     = iss_r + NCNT_W'(1);
          waddr_nxt   = waddr_r + WA_W'(MAX_INNER);
        end
        if (mac_done) begin
          oc_nxt    = '0;
          state_nxt = row_end_r ? S_OUT_RD : S_IDLE;
        end
      end
      S_OUT_RD: begin
        acc_re    = 1'b1;
        b_re      = 1'b1;
        state_nxt = S_OUT_SUM;
      end
      S_OUT_SUM: begin
        if (out_free) begin
          out_load = 1'b1;
          out_nxt.result   = sat;
          out_nxt.column   = 4'(oc_r);
          out_nxt.row_last = ((oc_r + NCNT_W'(1)) == ncol);
          if (out_nxt.row_last) begin
            acc_vld_nxt = '0;
            state_nxt   = S_IDLE;
          end else begin
            oc_nxt    = oc_r + NCNT_W'(1);
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      sc_r          <= '0;
      row_end_r     <= 1'b0;
      iss_r         <= '0;
      st1_vld_r     <= 1'b0;
      oc_r          <= '0;
      acc_vld_r     <= '0;
      out_valid_r   <= 1'b0;
      inner_size_r  <= lfw_pkg::INNER_SIZE_RST;
      out_size_r    <= lfw_pkg::OUT_SIZE_RST;
      bias_enable_r <= lfw_pkg::BIAS_ENABLE_RST;
    end else begin
      state_r     <= state_nxt;
      sc_r        <= sc_nxt;
      row_end_r   <= row_end_nxt;
      iss_r       <= iss_nxt;
      st1_vld_r   <= st1_vld_nxt;
      oc_r        <= oc_nxt;
      acc_vld_r   <= acc_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          lfw_pkg::CFG_INNER_SIZE:  inner_size_r  <= cfg_wdata[6:0];
          lfw_pkg::CFG_OUT_SIZE:    out_size_r    <= cfg_wdata[4:0];
          lfw_pkg::CFG_BIAS_ENABLE: bias_enable_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
    x_r       <= x_nxt;
    waddr_r   <= waddr_nxt;
    st1_col_r <= st1_col_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Stores
  lfw_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (WA_W'(in_data.index)),
    .wdata (in_data.value),
    .re    (w_re),
    .raddr (waddr_r),
    .rdata (w_rdata)
  );

  lfw_ram #(.WIDTH(16), .DEPTH(MAX_OUT)) u_bias_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (COL_W'(in_data.index)),
    .wdata (in_data.value),
    .re    (b_re),
    .raddr (oc_r[COL_W-1:0]),
    .rdata (b_rdata)
  );

  lfw_ram #(.WIDTH(ACC_W), .DEPTH(MAX_OUT)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .re    (acc_re),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  lfw_mac #(.COL_W(COL_W)) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (mac_ctl),
    .col_i     (st1_col_r),
    .x_i       (x_r),
    .w_i       (w_rdata),
    .acc_i     (acc_rdata),
    .wr_en_o   (acc_we),
    .wr_addr_o (acc_waddr),
    .wr_data_o (acc_wdata)
  );

`ifndef NO_ASSERTIONS
  // accumulator writes only come from the MAC sweep
  a_acc_we_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
    acc_we |-> state_r == S_MAC)
    else $error("accumulator write outside MAC sweep");

  // column issue never runs past the active column count
  a_iss_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MAC |-> iss_r <= ncol)
    else $error("column issue beyond ncol");

  // last result of a row returns to idle with a fresh accumulator set
  a_row_close: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT_SUM && out_free && (oc_r + NCNT_W'(1)) == ncol)
      |=> state_r == S_IDLE && acc_vld_r == '0 && sc_r == '0)
    else $error("row not closed after last result");

  // a new result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> !(state_r == S_IDLE && $past(state_r) == S_OUT_SUM)
      || $stable(out_r))
    else $error("output overwritten while stalled");
`endif

endmodule

`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for linear_layer_forward_top: stores, row accumulation, saturation.
`timescale 1ns / 1ps

module tb;

  localparam int MAX_INNER   = 64;
  localparam int MAX_OUT     = 16;
  localparam int HOLD_CYCLES = 300;   // long output back-pressure stretch
  localparam int TAIL_CYCLES = 48;    // longer than one sample's MAC sweep, with margin
  localparam int WATCH_LIMIT = 3000;  // cycles with no transaction on either side

  // func code 3 is not defined by the block; it must be dropped silently
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  lfw_pkg::in_item_t             in_data   = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  lfw_pkg::out_item_t            out_data;
  logic                          cfg_we    = 1'b0;
  logic [lfw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lfw_pkg::CFG_W-1:0]     cfg_wdata = '0;

  linear_layer_forward_top #(
    .MAX_INNER(MAX_INNER),
    .MAX_OUT  (MAX_OUT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial forever #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Layer predictor: its own copy of the stores, accumulators and registers.
  // ---------------------------------------------------------------------------
  logic signed [15:0]               weight_mem [MAX_OUT*MAX_INNER];
  logic signed [15:0]               bias_mem   [MAX_OUT];
  logic signed [lfw_pkg::ACC_W-1:0] acc_mem    [MAX_OUT];
  int unsigned                      row_fill;     // samples accumulated in the current row
  logic [6:0]                       reg_inner;
  logic [4:0]                       reg_out;
  logic                             reg_bias;

  lfw_pkg::out_item_t expected_features [$];  // Q16.16 outputs still owed by the block
  lfw_pkg::in_item_t  pending_txns [$];       // input transactions not yet offered

  int errors      = 0;
  int n_samples   = 0;
  int n_rows      = 0;
  int n_checked   = 0;
  int n_settings  = 0;

  // Register values outside the legal range clamp when used
  function automatic int active_inner();
    if (reg_inner < 1) return 1;
    if (reg_inner > MAX_INNER) return MAX_INNER;
    return int'(reg_inner);
  endfunction

  function automatic int active_cols();
    if (reg_out < 1) return 1;
    if (reg_out > MAX_OUT) return MAX_OUT;
    return int'(reg_out);
  endfunction

  function automatic void layer_reset();
    foreach (weight_mem[i]) weight_mem[i] = '0;
    foreach (bias_mem[i]) bias_mem[i] = '0;
    foreach (acc_mem[i]) acc_mem[i] = '0;
    row_fill  = 0;
    reg_inner = lfw_pkg::INNER_SIZE_RST;
    reg_out   = lfw_pkg::OUT_SIZE_RST;
    reg_bias  = lfw_pkg::BIAS_ENABLE_RST;
  endfunction

  // Apply one accepted input transaction; queue the row's outputs when it closes.
  function automatic void layer_apply(lfw_pkg::in_item_t t);
    int                 feat;
    int                 ncol;
    longint             prod;
    longint             sum;
    lfw_pkg::out_item_t r;
    ncol = active_cols();
    case (t.func)
      lfw_pkg::FUNC_WEIGHT: weight_mem[t.index] = t.value;
      lfw_pkg::FUNC_BIAS: begin
        if (t.index < MAX_OUT) bias_mem[t.index] = t.value;
      end
      lfw_pkg::FUNC_SAMPLE: begin
        n_samples++;
        feat = (row_fill >= MAX_INNER) ? MAX_INNER - 1 : int'(row_fill);
        for (int c = 0; c < ncol; c++) begin
          prod = longint'($signed(t.value)) * longint'(weight_mem[c*MAX_INNER+feat]);
          acc_mem[c] = acc_mem[c] + prod;  // truncation gives the 40-bit wrap
        end
        row_fill++;
        if (row_fill >= active_inner()) begin
          n_rows++;
          for (int c = 0; c < ncol; c++) begin
            sum = acc_mem[c];
            if (reg_bias) sum += longint'(bias_mem[c]) * 256;  // Q8.8 -> Q16.16
            if (sum > longint'(lfw_pkg::SAT_MAX)) sum = lfw_pkg::SAT_MAX;
            if (sum < longint'(lfw_pkg::SAT_MIN)) sum = lfw_pkg::SAT_MIN;
            r.result   = sum[31:0];
            r.column   = c[3:0];
            r.row_last = (c == ncol - 1);
            expected_features.push_back(r);
          end
          foreach (acc_mem[i]) acc_mem[i] = '0;
          row_fill = 0;
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation. Tracks which store words were written so that no
  // sample ever reads a weight or bias that was never loaded.
  // ---------------------------------------------------------------------------
  bit w_loaded [MAX_OUT*MAX_INNER];
  bit b_loaded [MAX_OUT];
  int plan_fill = 0;                     // row position as seen by the generator

  function automatic void push_txn(logic [1:0] f, int idx, int val);
    lfw_pkg::in_item_t t;
    t.func  = f;
    t.index = idx[9:0];
    t.value = val[15:0];
    if (f == lfw_pkg::FUNC_WEIGHT) w_loaded[idx[9:0]] = 1'b1;
    if (f == lfw_pkg::FUNC_BIAS && idx < MAX_OUT) b_loaded[idx] = 1'b1;
    pending_txns.push_back(t);
  endfunction

  // Extremes and zero show up often; otherwise any Q8.8 value
  function automatic int rand_value();
    case ($urandom_range(0, 7))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // Queue a sample, first loading any weight or bias it will need.
  function automatic void push_sample(int val);
    int ncol;
    ncol = active_cols();
    for (int c = 0; c < ncol; c++) begin
      if (!w_loaded[c*MAX_INNER+plan_fill])
        push_txn(lfw_pkg::FUNC_WEIGHT, c*MAX_INNER + plan_fill, rand_value());
    end
    if (reg_bias && plan_fill + 1 >= active_inner()) begin
      for (int c = 0; c < ncol; c++) begin
        if (!b_loaded[c]) push_txn(lfw_pkg::FUNC_BIAS, c, rand_value());
      end
    end
    // index is ignored on samples; random so its bits toggle anyway
    push_txn(lfw_pkg::FUNC_SAMPLE, $urandom_range(0, 1023), val);
    plan_fill++;
    if (plan_fill >= active_inner()) plan_fill = 0;
  endfunction

  // Mostly sample streams, with weight/bias rewrites and undefined-func noise
  function automatic void random_segment(int n_items);
    for (int k = 0; k < n_items; k++) begin
      case ($urandom_range(0, 19))
        0, 1: push_txn(lfw_pkg::FUNC_WEIGHT, $urandom_range(0, 1023), rand_value());
        2: push_txn(lfw_pkg::FUNC_BIAS, $urandom_range(0, 1) ? $urandom_range(0, 31)
                                                             : $urandom_range(0, 1023),
                    rand_value());
        3: push_txn(FUNC_UNUSED, $urandom_range(0, 1023), rand_value());
        default: push_sample(rand_value());
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: drives at the falling edge, holds the payload until taken.
  // ---------------------------------------------------------------------------
  logic in_taken = 1'b0;                 // last rising edge moved a transaction
  bit   idle_on  = 1'b1;                 // random gaps/stalls allowed
  int   in_gap   = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        in_gap   <= $urandom_range(0, 10);  // random idle gap before the next offer
        in_valid <= 1'b0;
      end else if (pending_txns.size() != 0) begin
        in_data  <= pending_txns.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output stall driver: random bursts, plus a long hold on request.
  // ---------------------------------------------------------------------------
  int hold_asks   = 0;
  int hold_served = 0;
  int hold_left   = 0;
  int stall_left  = 0;

  always @(negedge clk) begin
    if (hold_served != hold_asks) begin
      hold_served <= hold_asks;
      hold_left   <= HOLD_CYCLES - 1;
      out_stall   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 10);  // random stall burst
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on every accepted input transaction, checks every
  // accepted output transaction against the oldest expectation.
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin : monitor
    lfw_pkg::out_item_t want;
    if (!rst_n) begin
      in_taken     <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) layer_apply(in_data);
      if (out_valid && !out_stall) begin
        if (expected_features.size() == 0) begin
          $display("%0t: unexpected output: result %h column %0d last %0b",
                   $time, out_data.result, out_data.column, out_data.row_last);
          errors++;
        end else begin
          want = expected_features.pop_front();
          n_checked++;
          if (out_data.result !== want.result || out_data.column !== want.column ||
              out_data.row_last !== want.row_last) begin
            $display("%0t: mismatch: expected result %h column %0d last %0b, got %h %0d %0b",
                     $time, want.result, want.column, want.row_last,
                     out_data.result, out_data.column, out_data.row_last);
            errors++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: nothing moved for too long
  always @(posedge clk) begin
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d outputs outstanding",
               $time, quiet_cycles, expected_features.size());
      $display("linear_layer_forward_top regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration and sequencing
  // ---------------------------------------------------------------------------
  task automatic cfg_write(logic [lfw_pkg::CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[lfw_pkg::CFG_W-1:0];
    case (idx)
      lfw_pkg::CFG_INNER_SIZE:  reg_inner = val[6:0];
      lfw_pkg::CFG_OUT_SIZE:    reg_out   = val[4:0];
      lfw_pkg::CFG_BIAS_ENABLE: reg_bias  = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(int inner, int cols, int bias_on);
    cfg_write(lfw_pkg::CFG_INNER_SIZE, inner);
    cfg_write(lfw_pkg::CFG_OUT_SIZE, cols);
    cfg_write(lfw_pkg::CFG_BIAS_ENABLE, bias_on);
    n_settings++;
  endtask

  // Sender pauses until every owed output has come back and the block is quiet.
  // Checked on the rising edge, where the driver never changes anything.
  task automatic drain();
    while (pending_txns.size() != 0 || in_valid || expected_features.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  initial begin
    layer_reset();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- Directed: two features, two columns, every func code ----------------
    set_config(2, 2, 1);
    push_txn(lfw_pkg::FUNC_WEIGHT, 0, -32768);
    push_txn(lfw_pkg::FUNC_WEIGHT, 1, -32768);
    push_txn(lfw_pkg::FUNC_WEIGHT, MAX_INNER, 32767);
    push_txn(lfw_pkg::FUNC_WEIGHT, MAX_INNER + 1, 32767);
    push_txn(lfw_pkg::FUNC_BIAS, 0, 32767);
    push_txn(lfw_pkg::FUNC_BIAS, 1, -32768);
    push_txn(lfw_pkg::FUNC_BIAS, 1023, 'h1234);   // beyond the bias store: dropped
    push_txn(FUNC_UNUSED, 1023, -1);              // undefined func: dropped
    // column 0 saturates high, column 1 saturates low
    push_sample(-32768);
    push_sample(-32768);
    push_sample(32767);
    push_sample(0);
    push_txn(lfw_pkg::FUNC_WEIGHT, 1023, 'h5a5a); // top of the weight store
    drain();

    // Both sizes written as zero clamp to one feature, one column; no bias
    set_config(0, 0, 0);
    push_sample(1);
    push_sample(-1);
    drain();

    // Register change mid-row: two of three samples in, then shrink the row
    // and add a column; the next sample closes the row at once
    set_config(3, 2, 1);
    push_sample(rand_value());
    push_sample(rand_value());
    drain();
    cfg_write(lfw_pkg::CFG_INNER_SIZE, 1);
    cfg_write(lfw_pkg::CFG_OUT_SIZE, 3);
    push_sample(rand_value());
    drain();

    // --- Random segments, small shapes; one stretch without idling ------------
    for (int s = 0; s < 6; s++) begin
      idle_on = (s != 3);
      set_config($urandom_range(1, 8), $urandom_range(1, 6), $urandom_range(0, 1));
      random_segment(10);
      drain();
    end

    // --- Back-pressure: one-sample rows, oversize out_size clamps to 16 -------
    idle_on = 1'b1;
    set_config(1, 31, 1);
    hold_asks++;
    for (int k = 0; k < 8; k++) push_sample(rand_value());
    drain();

    // --- Closing stretch with no idling on either side ----------------------
    idle_on = 1'b0;
    set_config($urandom_range(1, 6), $urandom_range(1, 8), 1);
    random_segment(10);
    drain();

    $display("covered %0d samples in %0d rows, %0d outputs checked, %0d register settings",
             n_samples, n_rows, n_checked, n_settings);
    $display("incl. saturation both ways, clamped sizes, mid-row changes, %0d-cycle hold",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("linear_layer_forward_top regression: pass");
    end else begin
      $display("linear_layer_forward_top regression: fail");
    end
    $finish;
  end

endmodule
